// File: src/rpn_pkg.sv
// Shared types, field widths and token codes of the postfix stack evaluator.
package rpn_pkg;

	// Field widths of one token and one result word
	localparam int WORD_W      = 64;
	localparam int ACT_W       = 3;
	localparam int VIDX_W      = 7;
	localparam int OP_W        = 4;
	localparam int DEPTH_W     = 9;
	localparam int ERR_W       = 2;
	localparam int IN_TDATA_W  = 80;
	localparam int OUT_TDATA_W = 80;

	// Default sizes of the stack and of the variable store
	localparam int STACK_DEPTH_DEF = 256;
	localparam int VAR_SLOTS_DEF   = 128;

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [ACT_W-1:0]  action_t;
	typedef logic [OP_W-1:0]   op_t;
	typedef logic [ERR_W-1:0]  err_t;

	// Token kinds
	localparam action_t ACT_PUSH_LIT   = 3'd0;
	localparam action_t ACT_PUSH_VAR   = 3'd1;
	localparam action_t ACT_APPLY      = 3'd2;
	localparam action_t ACT_END        = 3'd3;
	localparam action_t ACT_END_ASSIGN = 3'd4;

	// Operators
	localparam op_t OP_ADD  = 4'd0;
	localparam op_t OP_SUB  = 4'd1;
	localparam op_t OP_MUL  = 4'd2;
	localparam op_t OP_AND  = 4'd3;
	localparam op_t OP_OR   = 4'd4;
	localparam op_t OP_XOR  = 4'd5;
	localparam op_t OP_SHL  = 4'd6;
	localparam op_t OP_SAR  = 4'd7;
	localparam op_t OP_ROTL = 4'd8;
	localparam op_t OP_ROTR = 4'd9;
	localparam op_t OP_NOT  = 4'd10;

	// Error codes
	localparam err_t ERR_NONE  = 2'd0;
	localparam err_t ERR_UNDER = 2'd1;
	localparam err_t ERR_OVER  = 2'd2;

	// Operand bundle handed to the ALU: a is the entry below the top, b the top
	typedef struct packed {
		op_t   op;
		word_t a;
		word_t b;
	} alu_in_t;

endpackage

// File: src/rpn_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module rpn_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 256,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read; data holds while no read is issued
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: src/rpn_alu.sv
// 64-bit ALU of the evaluator, with a split multiplier built from registered partial products.
module rpn_alu (
	input  logic             clk,
	input  rpn_pkg::alu_in_t req,
	output rpn_pkg::word_t   result
);
	import rpn_pkg::*;

	logic [63:0]  pp_ll_q;
	logic [31:0]  pp_lh_q;
	logic [31:0]  pp_hl_q;
	logic [5:0]   amt;
	logic [127:0] rot_l;
	logic [127:0] rot_r;

	// Register the 32x32 partial products; operands hold while a multiply waits
	always_ff @(posedge clk) begin
		pp_ll_q <= 64'(req.a[31:0] * req.b[31:0]);
		pp_lh_q <= 32'(req.a[31:0] * req.b[63:32]);
		pp_hl_q <= 32'(req.a[63:32] * req.b[31:0]);
	end

	// Select the operation result
	always_comb begin
		amt    = req.b[5:0];
		rot_l  = {req.a, req.a} << amt;
		rot_r  = {req.a, req.a} >> amt;
		result = '0;
		case (req.op)
			OP_ADD:  result = req.a + req.b;
			OP_SUB:  result = req.a - req.b;
			OP_MUL:  result = pp_ll_q + {32'(pp_lh_q + pp_hl_q), 32'd0};
			OP_AND:  result = req.a & req.b;
			OP_OR:   result = req.a | req.b;
			OP_XOR:  result = req.a ^ req.b;
			OP_SHL:  result = req.a << amt;
			OP_SAR:  result = word_t'($signed(req.a) >>> amt);
			OP_ROTL: result = rot_l[127:64];
			OP_ROTR: result = rot_r[63:0];
			OP_NOT:  result = ~req.b;
			default: result = '0;
		endcase
	end

endmodule

// File: src/rpn_stack_evaluator_core.sv
// A token is registered into the execute stage on acceptance; its result word then goes to the output register.
// Throughput: one token per cycle unless the output stalls; a multiply holds the execute stage
// for a second phase while the 64x64 product is summed from registered 32x32 partial products.
// The top two stack entries live in registers, deeper entries in a one-port-pair RAM.
// Reset clears the stack pointer, the error flag and the per-slot valid bits of the
// variable store (unwritten slots read as zero); no clearing pass is needed.
module rpn_stack_evaluator_core #(
	parameter int STACK_DEPTH    = rpn_pkg::STACK_DEPTH_DEF,
	parameter int VARIABLE_SLOTS = rpn_pkg::VAR_SLOTS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// literal [63:0], var_index [70:64], operator [74:71], zero [79:75]
	input  logic [rpn_pkg::IN_TDATA_W-1:0]   s_tdata,
	// action [2:0]
	input  logic [rpn_pkg::ACT_W-1:0]        s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// top_value [63:0], stack_depth [72:64], zero [79:73]
	output logic [rpn_pkg::OUT_TDATA_W-1:0]  m_tdata,
	// expression_done
	output logic                             m_tlast,
	// error_code [1:0]
	output logic [rpn_pkg::ERR_W-1:0]        m_tuser
);
	import rpn_pkg::*;

	localparam int SPW = $clog2(STACK_DEPTH + 1);
	localparam int SAW = $clog2(STACK_DEPTH);
	localparam int VAW = (VARIABLE_SLOTS > 1) ? $clog2(VARIABLE_SLOTS) : 1;

	// Input token fields
	word_t           in_literal;
	logic [VIDX_W-1:0] in_vidx;
	op_t             in_op;
	logic [31:0]     in_vidx32;
	logic [VAW-1:0]  in_vaddr;
	logic            in_range;
	logic            accept;

	// Execute stage
	logic              valid_s1;
	action_t           act_s1;
	word_t             lit_s1;
	logic [VIDX_W-1:0] vidx_s1;
	op_t               op_s1;
	logic              vrange_s1;
	logic              vvalid_s1;
	logic              vfwd_s1;
	word_t             vfwd_data_s1;

	// Stack state
	logic [SPW-1:0] sp_q;
	word_t          top_q;
	word_t          second_q;
	word_t          third_q;
	logic           third_sel_q;
	err_t           sticky_q;
	logic           mul_phase_q;

	// Variable store
	logic [VARIABLE_SLOTS-1:0] var_valid_q;
	word_t                     var_rdata;
	logic [31:0]               wr_vidx32;
	logic [VAW-1:0]            var_waddr;
	logic                      var_we;

	// Stack RAM
	word_t          stk_rdata;
	logic [SAW-1:0] stk_waddr;
	logic [SAW-1:0] stk_raddr;
	logic           stk_we;
	logic           stk_re;

	// Step logic
	alu_in_t        alu_req;
	word_t          alu_result;
	word_t          third;
	word_t          var_val;
	word_t          push_val;
	logic [SPW-1:0] sp_n;
	word_t          top_n;
	word_t          second_n;
	word_t          third_n;
	logic           third_sel_n;
	err_t           flag;
	err_t           err_n;
	logic           is_end;
	logic           push_go;
	logic           pop_go;
	logic           need_mul;
	logic           out_space;
	logic           commit;
	word_t          res_top;
	logic [31:0]    res_depth32;
	err_t           res_err;

	// Output register
	logic           out_valid_q;
	word_t          out_top_q;
	logic [DEPTH_W-1:0] out_depth_q;
	logic           out_done_q;
	err_t           out_err_q;

	// Unpack the token and form the variable address
	assign in_literal = s_tdata[63:0];
	assign in_vidx    = s_tdata[70:64];
	assign in_op      = s_tdata[74:71];
	assign in_vidx32  = 32'(in_vidx);
	assign in_vaddr   = in_vidx32[VAW-1:0];
	assign in_range   = in_vidx32 < 32'(VARIABLE_SLOTS);
	assign accept     = s_tvalid && s_tready;

	// Handshake: take a token when the execute stage is empty or retiring
	assign out_space = !out_valid_q || m_tready;
	assign need_mul  = (act_s1 == ACT_APPLY) && (op_s1 == OP_MUL) && (sp_q >= SPW'(2));
	assign commit    = valid_s1 && out_space && (!need_mul || mul_phase_q);
	assign s_tready  = !valid_s1 || commit;

	// Variable store RAM, read at acceptance
	rpn_ram #(
		.WIDTH(WORD_W),
		.DEPTH(VARIABLE_SLOTS),
		.AW   (VAW)
	) u_var_ram (
		.clk  (clk),
		.we   (var_we),
		.waddr(var_waddr),
		.wdata(top_q),
		.re   (accept),
		.raddr(in_vaddr),
		.rdata(var_rdata)
	);

	// Stack RAM holding entries below the two cached ones
	rpn_ram #(
		.WIDTH(WORD_W),
		.DEPTH(STACK_DEPTH),
		.AW   (SAW)
	) u_stack_ram (
		.clk  (clk),
		.we   (stk_we),
		.waddr(stk_waddr),
		.wdata(second_q),
		.re   (stk_re),
		.raddr(stk_raddr),
		.rdata(stk_rdata)
	);

	assign wr_vidx32 = 32'(vidx_s1);
	assign var_waddr = wr_vidx32[VAW-1:0];
	assign stk_waddr = SAW'(sp_q - SPW'(2));
	assign stk_raddr = SAW'(sp_q - SPW'(4));

	// Load the execute stage, forwarding a same-cycle variable write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (commit) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			act_s1       <= s_tuser;
			lit_s1       <= in_literal;
			vidx_s1      <= in_vidx;
			op_s1        <= in_op;
			vrange_s1    <= in_range;
			vvalid_s1    <= in_range ? var_valid_q[in_vaddr] : 1'b0;
			vfwd_s1      <= var_we && in_range && (var_waddr == in_vaddr);
			vfwd_data_s1 <= top_q;
		end
	end

	// ALU operands: entry below the top and the top
	assign alu_req.op = op_s1;
	assign alu_req.a  = second_q;
	assign alu_req.b  = top_q;

	rpn_alu u_alu (
		.clk   (clk),
		.req   (alu_req),
		.result(alu_result)
	);

	// Step: compute the next stack state and the result word
	always_comb begin
		third       = third_sel_q ? stk_rdata : third_q;
		var_val     = !vrange_s1 ? '0 : (vfwd_s1 ? vfwd_data_s1 : (vvalid_s1 ? var_rdata : '0));
		push_val    = (act_s1 == ACT_PUSH_VAR) ? var_val : lit_s1;
		sp_n        = sp_q;
		top_n       = top_q;
		second_n    = second_q;
		third_n     = third_q;
		third_sel_n = third_sel_q;
		flag        = ERR_NONE;
		is_end      = 1'b0;
		push_go     = 1'b0;
		pop_go      = 1'b0;
		case (act_s1)
			ACT_PUSH_LIT, ACT_PUSH_VAR: begin
				if (sp_q >= SPW'(STACK_DEPTH)) begin
					flag = ERR_OVER;
				end else begin
					push_go     = 1'b1;
					top_n       = push_val;
					second_n    = top_q;
					third_n     = second_q;
					third_sel_n = 1'b0;
					sp_n        = sp_q + SPW'(1);
				end
			end
			ACT_APPLY: begin
				if (op_s1 == OP_NOT) begin
					if (sp_q == '0) begin
						flag = ERR_UNDER;
					end else begin
						top_n = alu_result;
					end
				end else if (op_s1 inside {[OP_ADD:OP_ROTR]}) begin
					if (sp_q < SPW'(2)) begin
						flag = ERR_UNDER;
					end else begin
						pop_go      = 1'b1;
						top_n       = alu_result;
						second_n    = third;
						third_sel_n = 1'b1;
						sp_n        = sp_q - SPW'(1);
					end
				end
			end
			ACT_END, ACT_END_ASSIGN: begin
				is_end = 1'b1;
				if (sp_q == '0) begin
					flag = ERR_UNDER;
				end
				sp_n = '0;
			end
			default: begin
			end
		endcase
		err_n = (sticky_q == ERR_NONE) ? flag : sticky_q;
		if (is_end) begin
			res_top     = (sp_q == '0) ? '0 : top_q;
			res_depth32 = '0;
		end else begin
			res_top     = (sp_n == '0) ? '0 : top_n;
			res_depth32 = 32'(sp_n);
		end
		res_err = err_n;
	end

	assign stk_we = commit && push_go && (sp_q >= SPW'(2));
	assign stk_re = commit && pop_go;
	assign var_we = commit && (act_s1 == ACT_END_ASSIGN) && (err_n == ERR_NONE) && vrange_s1;

	// Update control state of the stack
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q        <= '0;
			sticky_q    <= ERR_NONE;
			third_sel_q <= 1'b0;
			mul_phase_q <= 1'b0;
			var_valid_q <= '0;
		end else begin
			if (commit) begin
				sp_q        <= sp_n;
				sticky_q    <= is_end ? ERR_NONE : err_n;
				third_sel_q <= third_sel_n;
				mul_phase_q <= 1'b0;
			end else if (valid_s1 && need_mul) begin
				mul_phase_q <= 1'b1;
			end
			if (var_we) begin
				var_valid_q[var_waddr] <= 1'b1;
			end
		end
	end

	// Update cached stack entries
	always_ff @(posedge clk) begin
		if (commit) begin
			top_q    <= top_n;
			second_q <= second_n;
			third_q  <= third_n;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			out_top_q   <= res_top;
			out_depth_q <= res_depth32[DEPTH_W-1:0];
			out_done_q  <= is_end;
			out_err_q   <= res_err;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {(OUT_TDATA_W - WORD_W - DEPTH_W)'(0), out_depth_q, out_top_q};
	assign m_tlast  = out_done_q;
	assign m_tuser  = out_err_q;

`ifndef SYNTH
	// Stack pointer never passes the configured depth
	a_sp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= SPW'(STACK_DEPTH))
		else $error("stack pointer beyond depth");

	// Multiply second phase only while a token sits in the execute stage
	a_mul_phase: assert property (@(posedge clk) disable iff (!arst_n)
		mul_phase_q |-> valid_s1)
		else $error("multiply phase without token");

	// Error flag holds until an end retires
	a_sticky_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(sticky_q != ERR_NONE && !(commit && is_end)) |=> (sticky_q == $past(sticky_q)))
		else $error("sticky error changed before end");

	// Each retired token produces a result word
	a_commit_out: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> out_valid_q)
		else $error("retired token without result word");

	// Variable writes stay inside the store
	a_var_range: assert property (@(posedge clk) disable iff (!arst_n)
		var_we |-> (wr_vidx32 < 32'(VARIABLE_SLOTS)))
		else $error("variable write out of range");
`endif

endmodule

// File: tb/tb_rpn_stack_evaluator_core.sv
// Self-checking testbench of the postfix stack evaluator: directed tokens, then random expressions.
module tb_rpn_stack_evaluator_core;
	import rpn_pkg::*;

	localparam int STACK_N         = STACK_DEPTH_DEF;
	localparam int SLOT_N          = VAR_SLOTS_DEF;
	localparam int RANDOM_ITEMS    = 650;
	localparam int IDLE_LIMIT      = 5000;
	localparam int SETTLE_CYCLES   = 10;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int HOLD_OFF_AFTER  = 60;
	localparam int PRINT_CAP       = 100;

	// Codes outside the defined sets, ignored by the block
	localparam action_t ACT_UNUSED = 3'd7;
	localparam op_t     OP_UNUSED  = 4'd15;

	localparam word_t WORD_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam word_t WORD_MIN = 64'h8000_0000_0000_0000;

	typedef logic [VIDX_W-1:0]  slot_t;
	typedef logic [DEPTH_W-1:0] depth_t;

	typedef struct packed {
		word_t  top;
		depth_t depth;
		logic   done;
		err_t   err;
	} result_t;

	// One token; a fixed row carries its expected result word typed in
	typedef struct packed {
		action_t act;
		word_t   lit;
		slot_t   slot;
		op_t     op;
		logic    fixed;
		result_t want;
	} token_t;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;
	action_t                s_tuser;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   m_tlast;
	err_t                   m_tuser;

	rpn_stack_evaluator_core #(
		.STACK_DEPTH    (STACK_N),
		.VARIABLE_SLOTS (SLOT_N)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	always #10 clk = ~clk;

	// Evaluator state mirrored by the testbench
	word_t calc_stack [STACK_N];
	int    calc_sp;
	word_t var_store [SLOT_N];
	err_t  calc_err;

	int peak_depth, ends_seen, stores_seen, under_seen, over_seen;
	int taken_cnt, result_cnt, fail_cnt, live_cnt, idle_cycles;

	token_t  token_q[$];
	result_t pending_results[$];

	function automatic void flag_error(err_t code);
		if (calc_err == ERR_NONE)
			calc_err = code;
	endfunction

	function automatic void push_word(word_t v);
		if (calc_sp >= STACK_N) begin
			flag_error(ERR_OVER);
		end else begin
			calc_stack[calc_sp] = v;
			calc_sp++;
		end
		if (calc_sp > peak_depth)
			peak_depth = calc_sp;
	endfunction

	// Apply one token to the mirrored state and return the result word it causes
	function automatic result_t eval_token(action_t act, word_t lit, slot_t slot, op_t op);
		result_t r;
		word_t   a, b, y;
		int      n;
		r = '0;
		case (act)
			ACT_PUSH_LIT: push_word(lit);
			ACT_PUSH_VAR: push_word(int'(slot) < SLOT_N ? var_store[slot] : '0);
			ACT_APPLY: begin
				if (op == OP_NOT) begin
					if (calc_sp < 1)
						flag_error(ERR_UNDER);
					else
						calc_stack[calc_sp-1] = ~calc_stack[calc_sp-1];
				end else if (op <= OP_ROTR) begin
					if (calc_sp < 2) begin
						flag_error(ERR_UNDER);
					end else begin
						b = calc_stack[calc_sp-1];
						a = calc_stack[calc_sp-2];
						n = int'(b[5:0]);
						// shifts by the full width give zero, so a zero rotate needs no special case
						case (op)
							OP_ADD:  y = a + b;
							OP_SUB:  y = a - b;
							OP_MUL:  y = a * b;
							OP_AND:  y = a & b;
							OP_OR:   y = a | b;
							OP_XOR:  y = a ^ b;
							OP_SHL:  y = a << n;
							OP_SAR:  y = word_t'($signed(a) >>> n);
							OP_ROTL: y = (a << n) | (a >> (WORD_W - n));
							default: y = (a >> n) | (a << (WORD_W - n));
						endcase
						calc_sp--;
						calc_stack[calc_sp-1] = y;
					end
				end
			end
			ACT_END, ACT_END_ASSIGN: begin
				r.done = 1'b1;
				if (calc_sp == 0)
					flag_error(ERR_UNDER);
				else
					r.top = calc_stack[calc_sp-1];
				// a flagged expression stores nothing
				if (act == ACT_END_ASSIGN && calc_err == ERR_NONE && int'(slot) < SLOT_N) begin
					var_store[slot] = r.top;
					stores_seen++;
				end
				r.err = calc_err;
				ends_seen++;
				if (calc_err == ERR_UNDER)
					under_seen++;
				if (calc_err == ERR_OVER)
					over_seen++;
				calc_sp = 0;
				calc_err = ERR_NONE;
				return r;
			end
			default: ;
		endcase
		if (calc_sp > 0)
			r.top = calc_stack[calc_sp-1];
		r.depth = depth_t'(calc_sp);
		r.err = calc_err;
		return r;
	endfunction

	// Stimulus building
	function automatic void add_token(action_t act, word_t lit, slot_t slot, op_t op,
		logic fixed = 1'b0, result_t want = '0);
		token_t t;
		t.act = act;
		t.lit = lit;
		t.slot = slot;
		t.op = op;
		t.fixed = fixed;
		t.want = want;
		token_q.push_back(t);
		if (act <= ACT_END_ASSIGN && !(act == ACT_APPLY && op > OP_NOT))
			live_cnt++;
	endfunction

	function automatic word_t rand_word();
		return {$urandom, $urandom};
	endfunction

	function automatic word_t pick_literal();
		case ($urandom_range(0, 7))
			// amounts around the word size for shifts and rotates
			0: return word_t'($urandom_range(0, 70));
			1: begin
				case ($urandom_range(0, 3))
					0:       return WORD_MAX;
					1:       return WORD_MIN;
					2:       return '0;
					default: return '1;
				endcase
			end
			default: return rand_word();
		endcase
	endfunction

	// Mostly a few slots, so that stored values get read back
	function automatic slot_t pick_slot();
		if ($urandom_range(0, 3) != 0)
			return slot_t'($urandom_range(0, 7));
		return slot_t'($urandom);
	endfunction

	function automatic void push_operand();
		if ($urandom_range(0, 3) == 0)
			add_token(ACT_PUSH_VAR, rand_word(), pick_slot(), op_t'($urandom));
		else
			add_token(ACT_PUSH_LIT, pick_literal(), slot_t'($urandom), op_t'($urandom));
	endfunction

	function automatic void add_noise();
		if ($urandom_range(0, 1))
			add_token(action_t'($urandom_range(int'(ACT_END_ASSIGN) + 1, ACT_UNUSED)),
				rand_word(), slot_t'($urandom), op_t'($urandom));
		else
			add_token(ACT_APPLY, rand_word(), slot_t'($urandom),
				op_t'($urandom_range(int'(OP_NOT) + 1, OP_UNUSED)));
	endfunction

	function automatic void add_end();
		if ($urandom_range(0, 1))
			add_token(ACT_END, rand_word(), pick_slot(), op_t'($urandom));
		else
			add_token(ACT_END_ASSIGN, rand_word(), pick_slot(), op_t'($urandom));
	endfunction

	// Well-formed expression with random operands and operators
	function automatic void gen_expression();
		int  operands, d;
		bit  stop;
		operands = $urandom_range(1, 6);
		d = 0;
		stop = 0;
		while (!stop && (operands > 0 || d > 1)) begin
			if (operands > 0 && (d < 2 || $urandom_range(0, 1))) begin
				push_operand();
				operands--;
				d++;
			end else if ($urandom_range(0, 7) == 0) begin
				add_token(ACT_APPLY, rand_word(), slot_t'($urandom), OP_NOT);
			end else begin
				add_token(ACT_APPLY, rand_word(), slot_t'($urandom),
					op_t'($urandom_range(0, OP_ROTR)));
				d--;
			end
			if ($urandom_range(0, 11) == 0)
				add_noise();
			// leave extra entries behind now and then
			if (operands == 0 && d > 1 && $urandom_range(0, 9) == 0)
				stop = 1;
		end
		add_end();
	endfunction

	// Sequences that underflow or carry raw tokens of any kind
	function automatic void gen_broken();
		case ($urandom_range(0, 2))
			0: begin
				if ($urandom_range(0, 1))
					push_operand();
				add_token(ACT_APPLY, rand_word(), slot_t'($urandom),
					op_t'($urandom_range(0, OP_NOT)));
				repeat ($urandom_range(0, 3)) push_operand();
				add_end();
			end
			1: add_end();
			default: begin
				repeat ($urandom_range(1, 8))
					add_token(action_t'($urandom), rand_word(), slot_t'($urandom), op_t'($urandom));
				add_end();
			end
		endcase
	endfunction

	// Fill the stack to the top and push past it
	function automatic void gen_deep();
		repeat (STACK_N + $urandom_range(1, 4)) push_operand();
		repeat ($urandom_range(2, 6))
			add_token(ACT_APPLY, rand_word(), slot_t'($urandom), op_t'($urandom_range(0, OP_NOT)));
		add_end();
	endfunction

	function automatic int pick_gap(inout int calm);
		int r;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 2) begin
			calm = $urandom_range(20, 60);
			return 0;
		end
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	function automatic void report_mismatch(string what, word_t want, word_t got);
		fail_cnt++;
		if (fail_cnt <= PRINT_CAP)
			$display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
	endfunction

	// Predict each word taken on the input side
	always @(posedge clk) begin : take_tokens
		result_t r;
		if (arst_n && s_tvalid && s_tready) begin
			r = eval_token(s_tuser, s_tdata[WORD_W-1:0], s_tdata[WORD_W +: VIDX_W],
				s_tdata[WORD_W+VIDX_W +: OP_W]);
			if (token_q[taken_cnt].fixed)
				r = token_q[taken_cnt].want;
			pending_results.push_back(r);
			taken_cnt++;
		end
	end

	// Check each result word against the oldest expectation
	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			result_cnt++;
			if (pending_results.size() == 0) begin
				fail_cnt++;
				$display("%0t: result word with nothing expected, top %h depth %0d done %b error %0d",
					$time, m_tdata[WORD_W-1:0], m_tdata[WORD_W +: DEPTH_W], m_tlast, m_tuser);
			end else begin
				want = pending_results.pop_front();
				if (m_tdata[WORD_W-1:0] !== want.top)
					report_mismatch("top_value", want.top, m_tdata[WORD_W-1:0]);
				if (m_tdata[WORD_W +: DEPTH_W] !== want.depth)
					report_mismatch("stack_depth", word_t'(want.depth),
						word_t'(m_tdata[WORD_W +: DEPTH_W]));
				if (m_tlast !== want.done)
					report_mismatch("expression_done", word_t'(want.done), word_t'(m_tlast));
				if (m_tuser !== want.err)
					report_mismatch("error_code", word_t'(want.err), word_t'(m_tuser));
			end
		end
	end

	// Abort when no word moves on either side for too long
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == IDLE_LIMIT) begin
			$display("tb_rpn_stack_evaluator_core NOT OK");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Output side: random stalls, one long hold-off to back up the block
	initial begin : drain
		int gap, calm;
		bit held;
		m_tready <= 1'b0;
		calm = 0;
		held = 0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (!held && result_cnt >= HOLD_OFF_AFTER) begin
				held = 1;
				m_tready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
			end
			m_tready <= 1'b1;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			gap = pick_gap(calm);
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	end

	// Input side: build the token list, reset, then feed it
	initial begin : feed
		int     i, gap, calm, dir_live, deep_at;
		bit     deep_done;
		token_t t;
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= ACT_PUSH_LIT;
		calc_sp = 0;
		calc_err = ERR_NONE;
		foreach (var_store[k])
			var_store[k] = '0;
		peak_depth = 0;
		ends_seen = 0;
		stores_seen = 0;
		under_seen = 0;
		over_seen = 0;
		taken_cnt = 0;
		result_cnt = 0;
		fail_cnt = 0;
		live_cnt = 0;
		calm = 0;

		// Directed tokens; typed results where they are plain to see
		add_token(ACT_END,        '0, '0, OP_ADD, 1'b1, result_t'{'0, 9'd0, 1'b1, ERR_UNDER});
		add_token(ACT_PUSH_LIT,   WORD_MAX, '0, OP_ADD, 1'b1,
			result_t'{WORD_MAX, 9'd1, 1'b0, ERR_NONE});
		add_token(ACT_PUSH_LIT,   WORD_MIN, '0, OP_ADD, 1'b1,
			result_t'{WORD_MIN, 9'd2, 1'b0, ERR_NONE});
		add_token(ACT_APPLY,      '0, '0, OP_ADD);
		add_token(ACT_PUSH_LIT,   64'd65, '0, OP_ADD);
		add_token(ACT_APPLY,      '0, '0, OP_SHL);
		add_token(ACT_PUSH_LIT,   64'd63, '0, OP_ADD);
		add_token(ACT_APPLY,      '0, '0, OP_SAR);
		add_token(ACT_PUSH_LIT,   64'd4, '0, OP_ADD);
		add_token(ACT_APPLY,      '0, '0, OP_ROTL);
		add_token(ACT_PUSH_LIT,   64'd64, '0, OP_ADD);
		add_token(ACT_APPLY,      '0, '0, OP_ROTR);
		add_token(ACT_PUSH_LIT,   64'h0123_4567_89AB_CDEF, '0, OP_ADD);
		add_token(ACT_APPLY,      '0, '0, OP_MUL);
		add_token(ACT_PUSH_LIT,   WORD_MIN, '0, OP_ADD);
		add_token(ACT_APPLY,      '0, '0, OP_SUB);
		add_token(ACT_PUSH_LIT,   64'hF0F0_F0F0_0F0F_0F0F, '0, OP_ADD);
		add_token(ACT_APPLY,      '0, '0, OP_AND);
		add_token(ACT_PUSH_LIT,   64'h5555_0000_AAAA_0001, '0, OP_ADD);
		add_token(ACT_APPLY,      '0, '0, OP_OR);
		add_token(ACT_PUSH_VAR,   '0, 7'd127, OP_ADD, 1'b1, result_t'{'0, 9'd2, 1'b0, ERR_NONE});
		add_token(ACT_APPLY,      '0, '0, OP_XOR);
		add_token(ACT_APPLY,      '0, '0, OP_NOT);
		add_token(ACT_APPLY,      '0, '0, OP_UNUSED);
		add_token(ACT_UNUSED,     '1, '1, OP_ADD);
		add_token(ACT_END_ASSIGN, '0, 7'd5, OP_ADD);
		add_token(ACT_PUSH_VAR,   '0, 7'd5, OP_ADD);
		add_token(ACT_APPLY,      '0, '0, OP_ADD);
		add_token(ACT_END_ASSIGN, '0, 7'd6, OP_ADD);
		add_token(ACT_PUSH_VAR,   '0, 7'd6, OP_ADD, 1'b1, result_t'{'0, 9'd1, 1'b0, ERR_NONE});
		add_token(ACT_PUSH_LIT,   '1, '0, OP_ADD, 1'b1, result_t'{'1, 9'd2, 1'b0, ERR_NONE});
		add_token(ACT_END,        '0, '0, OP_ADD, 1'b1, result_t'{'1, 9'd0, 1'b1, ERR_NONE});

		// Random part: mostly well-formed expressions, one run past the stack top
		dir_live = live_cnt;
		deep_at = $urandom_range(100, 400);
		deep_done = 0;
		while (live_cnt - dir_live < RANDOM_ITEMS) begin
			if (!deep_done && live_cnt - dir_live >= deep_at) begin
				gen_deep();
				deep_done = 1;
			end else if ($urandom_range(0, 9) == 0) begin
				gen_broken();
			end else begin
				gen_expression();
			end
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		for (i = 0; i < token_q.size(); i++) begin
			t = token_q[i];
			gap = pick_gap(calm);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			s_tvalid <= 1'b1;
			s_tdata <= {{(IN_TDATA_W-WORD_W-VIDX_W-OP_W){1'b0}}, t.op, t.slot, t.lit};
			s_tuser <= t.act;
			@(posedge clk);
			while (!s_tready)
				@(posedge clk);
		end
		s_tvalid <= 1'b0;

		// Drain the outstanding words, then allow for the pipeline
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Ran %0d tokens, %0d result words; %0d expressions ended, %0d stored to a slot",
			taken_cnt, result_cnt, ends_seen, stores_seen);
		$display("Ends flagged with underflow %0d, with overflow %0d; deepest stack %0d of %0d",
			under_seen, over_seen, peak_depth, STACK_N);
		if (fail_cnt == 0)
			$display("tb_rpn_stack_evaluator_core OK");
		else
			$display("tb_rpn_stack_evaluator_core NOT OK");
		$finish;
	end

endmodule
